// ----- rtl/gsf_pkg.sv -----
// ============================================================================
// gsf_pkg: shared types and constants for the Gaussian smoothing FIR
// Holds the word types of both channels, the configuration register indexes,
// the border modes, the sequencer states and the fixed sizes of the filter.
// ============================================================================
package gsf_pkg;

    // Block store and kernel sizes.
    localparam int MAX_LEN  = 64;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int RADIUS   = 6;
    localparam int NUM_TAPS = 2 * RADIUS + 1;
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam int NUM_COEF = 7;
    localparam int DIST_W   = $clog2(NUM_COEF);

    // Datapath widths.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W    = PROD_W + 3;
    localparam int POS_W    = CNT_W + 3;
    localparam int FRAC_W   = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 3'd1;

    // Reset weights, center tap first, then distance one to six.
    localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
        16'd4490, 16'd4248, 16'd3595, 16'd2723, 16'd1846, 16'd1120, 16'd608
    };

    // Border extension modes; other codes act as zero padding.
    typedef enum logic [MODE_W-1:0] {
        BM_ZERO       = 3'd0,
        BM_REPLICATE  = 3'd1,
        BM_REFLECT    = 3'd2,
        BM_WRAP       = 3'd3,
        BM_REFLECT101 = 3'd4
    } t_border_mode;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_TAPS,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Input word.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_sample;
    } t_in_item;

    // Output word.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_sample;
        logic                       end_of_block;
        logic                       overflow_flag;
    } t_out_item;

endpackage

// ----- rtl/gaussian_smoothing_fir.sv -----
// ============================================================================
// gaussian_smoothing_fir: block-based 13-tap symmetric smoothing filter
// Collects up to 64 signed samples, then emits one rounded, saturated
// smoothed sample per stored sample with a selectable border extension.
// ============================================================================
// While loading, the block accepts one input word per cycle until one
// carries last_sample. It then stalls its input and computes the outputs in
// order with one shared multiply-accumulate: it issues the 13 taps, drains
// the memory read and multiplier registers and then hands over the output
// word, which waits for as long as the output is stalled. New words are
// accepted only after the last output word of the block has been taken.
// Samples beyond 64 are dropped and every output of that block carries
// overflow_flag. Configuration writes are taken in every cycle and must only
// happen while the block is idle.
module gaussian_smoothing_fir
    import gsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    // Output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    // Configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Registers
    t_state                     r_state, n_state;
    logic [MODE_W-1:0]          r_border_mode;
    logic [COEF_W-1:0]          r_coef [NUM_COEF];
    logic [CNT_W-1:0]           r_count;
    logic                       r_dropped;
    logic [MODE_W-1:0]          r_eff_mode;
    logic [ADDR_W-1:0]          r_idx;
    logic [TAP_W-1:0]           r_tap;
    logic                       r_p1_vld;
    logic                       r_p1_use;
    logic [COEF_W-1:0]          r_p1_coef;
    logic signed [SAMPLE_W-1:0] r_mem_q;
    logic                       r_p2_vld;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_vld;
    t_out_item                  r_out;
    logic signed [SAMPLE_W-1:0] r_store [MAX_LEN];

    // Control from the sequencer
    logic in_acc;
    logic out_ack;
    logic issue;
    logic drain_done;
    logic is_last_tap;
    logic is_last_out;

    // Datapath signals
    logic [CNT_W-1:0]           n_count;
    logic                       store_full;
    logic                       mem_we;
    logic signed [POS_W-1:0]    pos;
    logic signed [POS_W-1:0]    len_s;
    logic signed [POS_W-1:0]    k_pos;
    logic                       tap_use;
    logic [ADDR_W-1:0]          rd_addr;
    logic [DIST_W-1:0]          tap_dist;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    acc_q;
    logic signed [SAMPLE_W-1:0] sat_q;

    // Handshake and sequencer status
    assign in_acc      = i_valid && !o_stall;
    assign out_ack     = r_out_vld && !i_stall;
    assign is_last_tap = (r_tap == TAP_W'(NUM_TAPS - 1));
    assign is_last_out = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
    assign drain_done  = !r_p1_vld && !r_p2_vld;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_data.last_sample) begin
                    n_state = ST_TAPS;
                end
            end
            ST_TAPS: begin
                if (is_last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ack) begin
                    n_state = is_last_out ? ST_LOAD : ST_TAPS;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_stall = 1'b1;
        issue   = 1'b0;
        case (r_state)
            ST_LOAD:  o_stall = 1'b0;
            ST_TAPS:  issue   = 1'b1;
            ST_DRAIN: issue   = 1'b0;
            ST_OUT:   issue   = 1'b0;
            default: begin
                o_stall = 1'b1;
                issue   = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_data      = r_out;

    // Sample count after the current word
    assign store_full = (r_count == CNT_W'(MAX_LEN));
    assign mem_we     = in_acc && !store_full;
    assign n_count    = store_full ? r_count : r_count + CNT_W'(1);

    // Padded position of the current tap and its border mapping
    assign pos   = $signed(POS_W'(r_idx) + POS_W'(r_tap) - POS_W'(RADIUS));
    assign len_s = $signed(POS_W'(r_count));

    always_comb begin
        k_pos = pos;
        if (pos < 0 || pos >= len_s) begin
            case (r_eff_mode)
                BM_REPLICATE:  k_pos = (pos < 0) ? '0 : len_s - POS_W'(1);
                BM_REFLECT:    k_pos = (pos < 0) ? -pos - POS_W'(1)
                                                 : (len_s <<< 1) - pos - POS_W'(1);
                BM_WRAP:       k_pos = (pos < 0) ? len_s + pos : pos - len_s;
                BM_REFLECT101: k_pos = (pos < 0) ? -pos
                                                 : (len_s <<< 1) - pos - POS_W'(2);
                default:       k_pos = $signed({POS_W{1'b1}});
            endcase
        end
    end

    assign tap_use  = (k_pos >= 0) && (k_pos < len_s);
    assign rd_addr  = k_pos[ADDR_W-1:0];
    assign tap_dist = (r_tap >= TAP_W'(RADIUS)) ? DIST_W'(r_tap - TAP_W'(RADIUS))
                                                : DIST_W'(TAP_W'(RADIUS) - r_tap);

    // Round half up, floor shift, saturate
    assign acc_rnd = r_acc + ACC_W'(1 << (FRAC_W - 1));
    assign acc_q   = acc_rnd >>> FRAC_W;

    always_comb begin
        if (acc_q > ACC_W'(32767)) begin
            sat_q = 16'sh7FFF;
        end else if (acc_q < -ACC_W'(32768)) begin
            sat_q = 16'sh8000;
        end else begin
            sat_q = acc_q[SAMPLE_W-1:0];
        end
    end

    // Sample store, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_count[ADDR_W-1:0]] <= i_data.sample_in;
        end
        r_mem_q <= r_store[rd_addr];
    end

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_tap     <= '0;
            r_idx     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;

            // Block loading
            if (in_acc) begin
                r_count <= n_count;
                if (store_full) begin
                    r_dropped <= 1'b1;
                end
                r_idx <= '0;
                r_tap <= '0;
            end

            // Tap counter
            if (issue) begin
                r_tap <= is_last_tap ? '0 : r_tap + TAP_W'(1);
            end

            // Output register
            if (r_state == ST_DRAIN && drain_done) begin
                r_out_vld <= 1'b1;
            end else if (out_ack) begin
                r_out_vld <= 1'b0;
                if (is_last_out) begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                end else begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
            end
        end
    end

    // Effective border mode, frozen for the block on its last word; short blocks use zero padding
    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.last_sample) begin
            if (n_count <= CNT_W'(RADIUS)) begin
                r_eff_mode <= BM_ZERO;
            end else begin
                r_eff_mode <= r_border_mode;
            end
        end
    end

    // Shared multiply-accumulate
    always_ff @(posedge i_clk) begin
        r_p1_use  <= tap_use;
        r_p1_coef <= r_coef[tap_dist];
        if (r_p1_use) begin
            r_prod <= $signed({1'b0, r_p1_coef}) * r_mem_q;
        end else begin
            r_prod <= '0;
        end
        if ((in_acc && i_data.last_sample) || (out_ack && !is_last_out)) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Result word captured when the accumulation is complete
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN && drain_done) begin
            r_out.filtered_sample <= sat_q;
            r_out.end_of_block    <= is_last_out;
            r_out.overflow_flag   <= r_dropped;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_mode <= BM_ZERO;
            for (int c = 0; c < NUM_COEF; c++) begin
                r_coef[c] <= COEF_RESET[c];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BORDER_MODE: r_border_mode <= i_cfg_data[MODE_W-1:0];
                default: r_coef[DIST_W'(i_cfg_index - CFG_COEF_CENTER)] <= i_cfg_data;
            endcase
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: self-checking testbench for the Gaussian smoothing FIR
// Sends blocks of signed samples through the input channel, predicts every
// smoothed output word from its own model of the filter and compares it with
// what the block emits. It runs through several border modes and weight sets
// and adds random idle cycles on both channels.
// ============================================================================
module tb_top;
    import gsf_pkg::*;

    // Weight sets used across the configuration phases.
    typedef enum int {
        WS_GAUSS,
        WS_RANDOM_Q15,
        WS_IDENTITY,
        WS_ZERO,
        WS_RANDOM_FULL,
        WS_MAX
    } t_weight_set;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_item              i_data      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Pending input words and expected output words.
    t_in_item  sample_words_q[$];
    t_out_item smoothed_q[$];
    int        mismatch_count = 0;

    // Predictor state: configuration and the block being collected.
    logic [MODE_W-1:0]       cfg_mode = BM_ZERO;
    logic [COEF_W-1:0]       cfg_coef [NUM_COEF] = COEF_RESET;
    logic signed [SAMPLE_W-1:0] blk_store [MAX_LEN];
    int                      blk_count   = 0;
    logic                    blk_dropped = 1'b0;

    // Random idling is switched off for a stretch of the run.
    int   cycle_no = 0;
    logic quiet;
    assign quiet = (cycle_no >= 2000) && (cycle_no < 5000);

    gaussian_smoothing_fir dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Sample at a padded position, following the border extension mode.
    function automatic longint padded_sample(int pos, int n, logic [MODE_W-1:0] mode);
        int k;
        k = pos;
        if (pos < 0 || pos > n - 1) begin
            case (mode)
                BM_REPLICATE:  k = (pos < 0) ? 0 : n - 1;
                BM_REFLECT:    k = (pos < 0) ? -pos - 1 : 2 * n - pos - 1;
                BM_WRAP:       k = (pos < 0) ? n + pos : pos - n;
                BM_REFLECT101: k = (pos < 0) ? -pos : 2 * n - pos - 2;
                default:       return 0;
            endcase
        end
        if (k < 0 || k >= n || k >= MAX_LEN) return 0;
        return longint'(blk_store[k]);
    endfunction

    // One smoothed sample: weighted tap sum, round half up, floor shift, saturate.
    function automatic logic signed [SAMPLE_W-1:0] smooth_at(int i, int n,
                                                             logic [MODE_W-1:0] mode);
        longint acc;
        longint q;
        int     ad;
        acc = 0;
        for (int d = -RADIUS; d <= RADIUS; d++) begin
            ad = (d < 0) ? -d : d;
            acc += longint'(cfg_coef[ad]) * padded_sample(i + d, n, mode);
        end
        acc += 16384;
        q = acc >>> FRAC_W;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // Take one accepted input word into the block; a final word releases the block.
    function automatic void absorb_word(t_in_item w);
        int                n;
        logic [MODE_W-1:0] mode;
        t_out_item         r;
        if (blk_count < MAX_LEN) begin
            blk_store[blk_count] = w.sample_in;
            blk_count++;
        end else begin
            blk_dropped = 1'b1;
        end
        if (w.last_sample) begin
            n = blk_count;
            mode = cfg_mode;
            // Short blocks always use zero padding.
            if (mode != BM_ZERO && n <= RADIUS) mode = BM_ZERO;
            for (int i = 0; i < n; i++) begin
                r.filtered_sample = smooth_at(i, n, mode);
                r.end_of_block    = (i == n - 1);
                r.overflow_flag   = blk_dropped;
                smoothed_q.push_back(r);
            end
            blk_count   = 0;
            blk_dropped = 1'b0;
        end
    endfunction

    // Input driver: presents queued words and records each accepted one.
    always @(posedge i_clk) begin : feeder
        logic hold_off;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) absorb_word(i_data);
            if (!i_valid || !o_stall) begin
                hold_off = !quiet && ($urandom_range(0, 99) < 7);
                if (sample_words_q.size() != 0 && !hold_off) begin
                    i_data  <= sample_words_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stall and comparison with the oldest expected word.
    always @(posedge i_clk) begin : out_monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (smoothed_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected output word: sample %0d end %b ovf %b",
                                 o_data.filtered_sample, o_data.end_of_block,
                                 o_data.overflow_flag);
                end else begin
                    want = smoothed_q.pop_front();
                    if (o_data.filtered_sample !== want.filtered_sample ||
                        o_data.end_of_block !== want.end_of_block ||
                        o_data.overflow_flag !== want.overflow_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Output mismatch: expected sample %0d end %b ovf %b,",
                                      " got sample %0d end %b ovf %b"},
                                     want.filtered_sample, want.end_of_block,
                                     want.overflow_flag, o_data.filtered_sample,
                                     o_data.end_of_block, o_data.overflow_flag);
                    end
                end
            end
            i_stall <= !quiet && ($urandom_range(0, 99) < 7);
        end
    end

    // Random sample with a bias toward the extremes.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Queue a block of random samples, the final word marked last.
    function automatic void queue_block(int len);
        t_in_item w;
        for (int i = 0; i < len; i++) begin
            w.sample_in   = pick_sample();
            w.last_sample = (i == len - 1);
            sample_words_q.push_back(w);
        end
    endfunction

    // Waits until every word is sent and every result is back, then lets the
    // block settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_words_q.size() != 0 || i_valid || smoothed_q.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    // One register write; the predictor follows once the write is taken.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BORDER_MODE) cfg_mode = val[MODE_W-1:0];
        else cfg_coef[idx - CFG_COEF_CENTER] = val;
    endtask

    // Writes the border mode and all seven weights.
    task automatic program_filter(logic [MODE_W-1:0] mode, t_weight_set ws);
        logic [COEF_W-1:0] w;
        write_reg(CFG_BORDER_MODE, CFG_DATA_W'(mode));
        for (int k = 0; k < NUM_COEF; k++) begin
            case (ws)
                WS_GAUSS:       w = COEF_RESET[k];
                WS_RANDOM_Q15:  w = COEF_W'($urandom_range(0, 32768));
                WS_IDENTITY:    w = (k == 0) ? 16'd32768 : 16'd0;
                WS_ZERO:        w = 16'd0;
                WS_RANDOM_FULL: w = COEF_W'($urandom_range(0, 65535));
                default:        w = 16'hFFFF;
            endcase
            write_reg(CFG_IDX_W'(CFG_COEF_CENTER + k), w);
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        int budget;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset weights, zero padding: single-word blocks and field extremes.
        sample_words_q.push_back('{16'sh7FFF, 1'b1});
        sample_words_q.push_back('{16'sh8000, 1'b1});
        sample_words_q.push_back('{16'sh7FFF, 1'b0});
        sample_words_q.push_back('{16'sh8000, 1'b0});
        sample_words_q.push_back('{16'sh0000, 1'b0});
        sample_words_q.push_back('{16'sh0001, 1'b0});
        sample_words_q.push_back('{16'shFFFF, 1'b0});
        sample_words_q.push_back('{16'sh7FFF, 1'b0});
        sample_words_q.push_back('{16'sh8000, 1'b1});
        wait_drained();

        // Weights just under two each with replicate mode: a short block that falls
        // back to zero padding, then a block that saturates both ways.
        program_filter(BM_REPLICATE, WS_MAX);
        for (int i = 0; i < 3; i++) sample_words_q.push_back('{16'sh7FFF, i == 2});
        for (int i = 0; i < 8; i++)
            sample_words_q.push_back('{(i < 4) ? 16'sh8000 : 16'sh7FFF, i == 7});
        wait_drained();

        // Random phases over every border mode, unknown codes included.
        for (int p = 0; p < 12; p++) begin
            program_filter(MODE_W'(p % 8), t_weight_set'(p % 6));
            // Full blocks, some with dropped words and a dropped final word.
            if (p % 6 == 1) queue_block(65 + $urandom_range(0, 3));
            if (p % 6 == 4) queue_block(MAX_LEN);
            budget = 12;
            while (budget > 0) begin
                len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, RADIUS)
                                                 : $urandom_range(RADIUS + 1, 24);
                queue_block(len);
                budget -= len;
            end
            wait_drained();
        end

        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && smoothed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- gaussian_smoothing_fir.f -----
rtl/gsf_pkg.sv
rtl/gaussian_smoothing_fir.sv
tb/tb_top.sv
